// ----- hdl/hptc_pkg.sv -----
// Shared types, codes and constants of the hashed page tag cache.
package hptc_pkg;

   // Hash mixing constants
   localparam logic [63:0] K_GOLDEN = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] K_MIX2   = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] K_MIX3   = 64'h94d049bb133111eb;

   // Response status codes
   localparam logic [1:0] ST_HIT    = 2'd0;
   localparam logic [1:0] ST_FILL   = 2'd1;
   localparam logic [1:0] ST_BYPASS = 2'd2;
   localparam logic [1:0] ST_BAD    = 2'd3;

   // Multiplier operand selection
   localparam logic [2:0] M_PG_LO = 3'd0;
   localparam logic [2:0] M_PG_HI = 3'd1;
   localparam logic [2:0] M_V2_LL = 3'd2;
   localparam logic [2:0] M_V2_LH = 3'd3;
   localparam logic [2:0] M_V2_HL = 3'd4;
   localparam logic [2:0] M_V3_LL = 3'd5;
   localparam logic [2:0] M_V3_LH = 3'd6;
   localparam logic [2:0] M_V3_HL = 3'd7;

   // Accumulator operations
   localparam logic [1:0] A_NONE  = 2'd0;
   localparam logic [1:0] A_SET   = 2'd1;
   localparam logic [1:0] A_ADDHI = 2'd2;

   // Hash word operations
   localparam logic [1:0] V_NONE  = 2'd0;
   localparam logic [1:0] V_MIX   = 2'd1;
   localparam logic [1:0] V_FIN27 = 2'd2;
   localparam logic [1:0] V_FIN31 = 2'd3;

   // Divider jobs
   localparam logic [1:0] D_BASE  = 2'd0;
   localparam logic [1:0] D_SHARD = 2'd1;
   localparam logic [1:0] D_SLOT  = 2'd2;

   localparam int DIV_BITS_PER_CYCLE = 4;
   localparam int DIV_CYCLES         = 64 / DIV_BITS_PER_CYCLE;
   localparam int HASH_STEPS         = 19;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] file;
      logic [63:0] offset;
      logic [31:0] page;
   } tag_type;

   typedef struct packed {
      logic       clr_step;
      logic       load;
      logic       mul_go;
      logic [2:0] mul_sel;
      logic [1:0] acc_op;
      logic [1:0] v_op;
      logic       div_start;
      logic [1:0] div_src;
      logic       addr_load;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic early;
      logic div_busy;
      logic rsp_free;
   } stat_type;

endpackage

// ----- hdl/hashed_page_tag_cache.sv -----
// Top level of the hashed page tag cache: controller plus datapath.
//
//  Channel  Direction  Handshake                   Contents
//  req      in         req_tvalid / req_tready     page request item
//  rsp      out        rsp_tvalid / rsp_tready     lookup result item
//  csr      in         csr_wr_en                   slot_count register
//
// An item is captured, hashed on a single shared 32x32 multiplier, divided
// on the radix-16 divider in two passes (shard, then slot), and then goes
// through address, tag read and compare. Invalid or uncached requests skip
// the hash and the shard and slot divisions.
// After reset a clearing pass over all MAX_SLOTS entries empties the tag store;
// req_tready stays low until it ends, while csr writes are taken at once.
// A new item is taken while the previous result still waits in the
// response register; an item stalls at its end only if that register is full.
module hashed_page_tag_cache #(
   parameter int MAX_SLOTS    = 4096,
   parameter int SHARD_CAP    = 64,
   parameter int REC_PER_PAGE = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // file_present[0], file_id[64:1], page_offset[128:65], page_number[160:129],
   // record_index[192:161], zero fill above
   input  logic [199:0] req_tdata,
   // page_kind[0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], shard_index[7:2], slot_pos[19:8], zero fill above
   output logic [23:0]  rsp_tdata,
   input  logic         csr_wr_en,
   input  logic [12:0]  csr_wr_data
);
   import hptc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequence each item through the datapath
   hptc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hash, divide, look up and hold the result
   hptc_datapath #(
      .MAX_SLOTS   (MAX_SLOTS),
      .SHARD_CAP   (SHARD_CAP),
      .REC_PER_PAGE(REC_PER_PAGE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule

// ----- hdl/hptc_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module hptc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- hdl/hptc_datapath.sv -----
// Datapath: request capture, hash, divider, slot address, tag store, response register.
module hptc_datapath #(
   parameter int MAX_SLOTS    = 4096,
   parameter int SHARD_CAP    = 64,
   parameter int REC_PER_PAGE = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  hptc_pkg::cmd_type  cmd,
   output hptc_pkg::stat_type stat,
   input  logic [199:0]       req_tdata,
   input  logic               req_tuser,
   input  logic               csr_wr_en,
   input  logic [12:0]        csr_wr_data,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata
);
   import hptc_pkg::*;

   localparam int AW    = $clog2(MAX_SLOTS > 1 ? MAX_SLOTS : 2);
   localparam int CW    = $clog2(MAX_SLOTS + 1);
   localparam int SHW   = $clog2(SHARD_CAP > 1 ? SHARD_CAP : 2);
   localparam int TAG_W = $bits(tag_type);

   logic [12:0]   slot_count_ff;
   logic [1:0]    kind_ff;
   logic [63:0]   file_ff, offset_ff;
   logic [31:0]   page_ff;
   logic          early_ff;
   logic [1:0]    early_st_ff;
   logic [63:0]   v_ff, acc_ff, prod_ff;
   logic [AW-1:0] clr_ff;
   logic          clr_done_ff;

   logic          div_busy_ff;
   logic [1:0]    div_src_ff;
   logic [3:0]    div_cnt_ff;
   logic [63:0]   div_q_ff;
   logic [CW-1:0] div_r_ff, div_d_ff;

   logic [CW-1:0]  base_ff;
   logic [SHW-1:0] extra_ff, shard_ff;
   logic [63:0]    quot_ff;
   logic [CW-1:0]  slot_ff;
   logic [AW-1:0]  at_ff;

   logic           rsp_valid_ff;
   logic [1:0]     rsp_st_ff;
   logic [5:0]     rsp_shard_ff;
   logic [11:0]    rsp_slot_ff;

   logic [CW-1:0]  slots, shards, count;
   logic [63:0]    kterm, mul_c, w, div_q_in;
   logic [31:0]    mul_a, mul_b;
   logic [CW-1:0]  div_r_in;
   logic           hit, ram_we;
   logic [AW-1:0]  ram_wa;
   tag_type        ram_wd, ram_rd, tag_rd;
   logic [SHW+CW:0] first;
   logic [31:0]    sh_ext, sl_ext;

   // Active slot and shard counts, and the size and first slot of the current shard
   always_comb begin
      slots  = (32'(slot_count_ff) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(slot_count_ff);
      shards = (32'(slots) < 32'(SHARD_CAP)) ? slots : CW'(SHARD_CAP);
      count  = base_ff + ((shard_ff < extra_ff) ? CW'(1) : CW'(0));
      first  = (SHW+CW+1)'(shard_ff) * (SHW+CW+1)'(base_ff)
             + ((shard_ff < extra_ff) ? (SHW+CW+1)'(shard_ff) : (SHW+CW+1)'(extra_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= 13'd4096;
      end else if (csr_wr_en) begin
         slot_count_ff <= csr_wr_data;
      end
   end

   // Capture request and classify
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= {1'b0, req_tuser} + 2'd1;
         file_ff   <= req_tdata[64:1];
         offset_ff <= req_tdata[128:65];
         page_ff   <= req_tdata[160:129];
         if (!req_tdata[0] || ({1'b0, req_tdata[192:161]} >= 33'(REC_PER_PAGE))) begin
            early_ff    <= 1'b1;
            early_st_ff <= ST_BAD;
         end else if (slots == '0) begin
            early_ff    <= 1'b1;
            early_st_ff <= ST_BYPASS;
         end else begin
            early_ff    <= 1'b0;
            early_st_ff <= ST_HIT;
         end
      end
   end

   // Hash: shared 32x32 multiplier, accumulator and hash word
   always_comb begin
      kterm = (kind_ff == 2'd2) ? {K_MIX3[62:0], 1'b0} : K_MIX3;
      case (cmd.mul_sel)
         M_V3_LL, M_V3_LH, M_V3_HL: mul_c = K_MIX3;
         default:                   mul_c = K_MIX2;
      endcase
      case (cmd.mul_sel)
         M_PG_LO, M_PG_HI:  mul_a = page_ff;
         M_V2_HL, M_V3_HL:  mul_a = v_ff[63:32];
         default:           mul_a = v_ff[31:0];
      endcase
      case (cmd.mul_sel)
         M_PG_HI, M_V2_LH, M_V3_LH: mul_b = mul_c[63:32];
         default:                   mul_b = mul_c[31:0];
      endcase
      w = v_ff ^ acc_ff ^ kterm;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_go) begin
         prod_ff <= mul_a * mul_b;
      end
      case (cmd.acc_op)
         A_SET:   acc_ff <= prod_ff;
         A_ADDHI: acc_ff <= acc_ff + {prod_ff[31:0], 32'd0};
         default: acc_ff <= acc_ff;
      endcase
      if (cmd.load) begin
         v_ff <= req_tdata[64:1] ^ (req_tdata[128:65] + K_GOLDEN
                 + {req_tdata[58:1], 6'd0} + {2'd0, req_tdata[64:3]});
      end else begin
         case (cmd.v_op)
            V_MIX:   v_ff <= w ^ {30'd0, w[63:30]};
            V_FIN27: v_ff <= acc_ff ^ {27'd0, acc_ff[63:27]};
            V_FIN31: v_ff <= acc_ff ^ {31'd0, acc_ff[63:31]};
            default: v_ff <= v_ff;
         endcase
      end
   end

   // Radix-16 restoring divider
   always_comb begin
      logic [CW:0]  r;
      logic [63:0]  q;
      r = {1'b0, div_r_ff};
      q = div_q_ff;
      for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
         r = {r[CW-1:0], q[63]};
         q = {q[62:0], 1'b0};
         if (r >= {1'b0, div_d_ff}) begin
            r    = r - {1'b0, div_d_ff};
            q[0] = 1'b1;
         end
      end
      div_r_in = r[CW-1:0];
      div_q_in = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff + 4'd1;
         if (div_cnt_ff == 4'(DIV_CYCLES - 1)) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_src_ff <= cmd.div_src;
         div_r_ff   <= '0;
         case (cmd.div_src)
            D_BASE:  begin div_q_ff <= 64'(slots);  div_d_ff <= shards; end
            D_SHARD: begin div_q_ff <= v_ff;        div_d_ff <= shards; end
            default: begin div_q_ff <= quot_ff;     div_d_ff <= count;  end
         endcase
      end else if (div_busy_ff) begin
         div_q_ff <= div_q_in;
         div_r_ff <= div_r_in;
         if (div_cnt_ff == 4'(DIV_CYCLES - 1)) begin
            case (div_src_ff)
               D_BASE:  begin base_ff <= div_q_in[CW-1:0]; extra_ff <= SHW'(div_r_in); end
               D_SHARD: begin quot_ff <= div_q_in;         shard_ff <= SHW'(div_r_in); end
               default: slot_ff <= div_r_in;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.addr_load) begin
         at_ff <= AW'(first + (SHW+CW+1)'(slot_ff));
      end
   end

   // Clearing sweep over the tag store after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + AW'(1);
         if (clr_ff == AW'(MAX_SLOTS - 1)) begin
            clr_done_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      tag_rd = ram_rd;
      hit    = (tag_rd.kind == kind_ff) && (tag_rd.file == file_ff)
            && (tag_rd.offset == offset_ff) && (tag_rd.page == page_ff);
      if (cmd.clr_step) begin
         ram_we = 1'b1;
         ram_wa = clr_ff;
         ram_wd = '0;
      end else begin
         ram_we = cmd.emit && !early_ff && !hit;
         ram_wa = at_ff;
         ram_wd = '{kind: kind_ff, file: file_ff, offset: offset_ff, page: page_ff};
      end
   end

   hptc_ram #(.WIDTH(TAG_W), .DEPTH(MAX_SLOTS)) u_tags (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(at_ff),
      .rd_data(ram_rd)
   );

   // Response register
   assign sh_ext = 32'(shard_ff);
   assign sl_ext = 32'(slot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (early_ff) begin
            rsp_st_ff    <= early_st_ff;
            rsp_shard_ff <= '0;
            rsp_slot_ff  <= '0;
         end else begin
            rsp_st_ff    <= hit ? ST_HIT : ST_FILL;
            rsp_shard_ff <= sh_ext[5:0];
            rsp_slot_ff  <= sl_ext[11:0];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_slot_ff, rsp_shard_ff, rsp_st_ff};

   assign stat.clr_last = clr_ff == AW'(MAX_SLOTS - 1);
   assign stat.early    = early_ff;
   assign stat.div_busy = div_busy_ff;
   assign stat.rsp_free = !rsp_valid_ff || rsp_tready;

   // The base division may be cut short by the next item after an early finish
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_start && (cmd.div_src != D_BASE)) |-> !div_busy_ff)
      else $error("divider restarted while busy");
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready)) else $error("response overwritten");
   a_load_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> clr_done_ff) else $error("item taken before tag store cleared");
endmodule

// ----- hdl/hptc_ctrl.sv -----
// Controller state machine sequencing clear, hash, divisions, lookup and response.
module hptc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  hptc_pkg::stat_type stat,
   output hptc_pkg::cmd_type  cmd
);
   import hptc_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_HASH  = 4'd2;
   localparam logic [3:0] S_DIVA  = 4'd3;
   localparam logic [3:0] S_DIVB  = 4'd4;
   localparam logic [3:0] S_DIVC  = 4'd5;
   localparam logic [3:0] S_ADDR  = 4'd6;
   localparam logic [3:0] S_READ  = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;

   // State sequence and hash program: multiply, then fold the product in, one step a cycle
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load      = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_src   = D_BASE;
               step_in       = '0;
               state_in      = S_HASH;
            end
         end
         S_HASH: begin
            if (stat.early) begin
               state_in = S_EMIT;
            end else begin
               case (step_ff)
                  5'd0:  begin cmd.mul_go = 1'b1; cmd.mul_sel = M_PG_LO; end
                  5'd1:  cmd.acc_op = A_SET;
                  5'd2:  begin cmd.mul_go = 1'b1; cmd.mul_sel = M_PG_HI; end
                  5'd3:  cmd.acc_op = A_ADDHI;
                  5'd4:  cmd.v_op = V_MIX;
                  5'd5:  begin cmd.mul_go = 1'b1; cmd.mul_sel = M_V2_LL; end
                  5'd6:  cmd.acc_op = A_SET;
                  5'd7:  begin cmd.mul_go = 1'b1; cmd.mul_sel = M_V2_LH; end
                  5'd8:  cmd.acc_op = A_ADDHI;
                  5'd9:  begin cmd.mul_go = 1'b1; cmd.mul_sel = M_V2_HL; end
                  5'd10: cmd.acc_op = A_ADDHI;
                  5'd11: cmd.v_op = V_FIN27;
                  5'd12: begin cmd.mul_go = 1'b1; cmd.mul_sel = M_V3_LL; end
                  5'd13: cmd.acc_op = A_SET;
                  5'd14: begin cmd.mul_go = 1'b1; cmd.mul_sel = M_V3_LH; end
                  5'd15: cmd.acc_op = A_ADDHI;
                  5'd16: begin cmd.mul_go = 1'b1; cmd.mul_sel = M_V3_HL; end
                  5'd17: cmd.acc_op = A_ADDHI;
                  default: cmd.v_op = V_FIN31;
               endcase
               step_in = step_ff + 5'd1;
               if (step_ff == 5'(HASH_STEPS - 1)) state_in = S_DIVA;
            end
         end
         S_DIVA: begin
            if (!stat.div_busy) begin
               cmd.div_start = 1'b1;
               cmd.div_src   = D_SHARD;
               state_in      = S_DIVB;
            end
         end
         S_DIVB: begin
            if (!stat.div_busy) begin
               cmd.div_start = 1'b1;
               cmd.div_src   = D_SLOT;
               state_in      = S_DIVC;
            end
         end
         S_DIVC: begin
            if (!stat.div_busy) state_in = S_ADDR;
         end
         S_ADDR: begin
            cmd.addr_load = 1'b1;
            state_in      = S_READ;
         end
         S_READ: state_in = S_EMIT;
         S_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end
endmodule

// ----- dv/tb.sv -----
// Self-checking testbench of the hashed page tag cache: scoreboard, stimulus and checks.
module tb;
   import hptc_pkg::*;

   localparam int SLOTS_MAX  = 4096;
   localparam int SHARDS_MAX = 64;
   localparam int REC_LIMIT  = 256;

   typedef struct packed {
      logic        kind;
      logic        present;
      logic [63:0] file;
      logic [63:0] offset;
      logic [31:0] page;
      logic [31:0] record;
   } page_req_type;

   // Packed from the top bit down: slot, shard, status in the lowest bits
   typedef struct packed {
      logic [11:0] slot;
      logic [5:0]  shard;
      logic [1:0]  status;
   } lookup_type;

   // Scoreboard: mirrors the tag store, predicts each lookup, queues expectations.
   class tag_scoreboard;
      logic [12:0] slot_count;
      logic [1:0]  tag_kind  [SLOTS_MAX];
      logic [63:0] tag_file  [SLOTS_MAX];
      logic [63:0] tag_offset[SLOTS_MAX];
      logic [31:0] tag_page  [SLOTS_MAX];
      lookup_type  pending[$];
      int          errors;
      int          checked;
      int          hits;
      int          fills;

      function new();
         slot_count = 13'd4096;
         for (int i = 0; i < SLOTS_MAX; i++) tag_kind[i] = 2'd0;
         errors = 0;
         checked = 0;
         hits = 0;
         fills = 0;
      endfunction

      function logic [63:0] mix(logic [63:0] kind, logic [63:0] file,
                                logic [63:0] offset, logic [63:0] page);
         logic [63:0] v;
         v = file;
         v ^= offset + K_GOLDEN + (v << 6) + (v >> 2);
         v ^= page * K_MIX2;
         v ^= kind * K_MIX3;
         v ^= v >> 30;
         v *= K_MIX2;
         v ^= v >> 27;
         v *= K_MIX3;
         return v ^ (v >> 31);
      endfunction

      function void note_request(page_req_type r);
         lookup_type  res;
         logic [63:0] slots, shards, base, extra, h, shard, count, slot, at;
         logic [1:0]  kind;
         kind = {1'b0, r.kind} + 2'd1;
         res = '0;
         slots = slot_count > SLOTS_MAX ? 64'(SLOTS_MAX) : 64'(slot_count);
         if (!r.present || r.record >= REC_LIMIT) begin
            res.status = ST_BAD;
         end else if (slots == 0) begin
            res.status = ST_BYPASS;
         end else begin
            shards = slots < SHARDS_MAX ? slots : 64'(SHARDS_MAX);
            base  = slots / shards;
            extra = slots % shards;
            h     = mix(64'(kind), r.file, r.offset, 64'(r.page));
            shard = h % shards;
            count = base + (shard < extra ? 1 : 0);
            slot  = (h / shards) % count;
            at    = shard * base + (shard < extra ? shard : extra) + slot;
            res.shard = shard[5:0];
            res.slot  = slot[11:0];
            if (tag_kind[at] == kind && tag_file[at] == r.file &&
                tag_offset[at] == r.offset && tag_page[at] == r.page) begin
               res.status = ST_HIT;
               hits++;
            end else begin
               tag_kind[at]   = kind;
               tag_file[at]   = r.file;
               tag_offset[at] = r.offset;
               tag_page[at]   = r.page;
               res.status = ST_FILL;
               fills++;
            end
         end
         pending.push_back(res);
      endfunction

      function void check_result(lookup_type got);
         lookup_type want;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
         if (got.shard !== want.shard) begin
            $display("%0t: shard expected %0d actual %0d", $time, want.shard, got.shard);
            errors++;
         end
         if (got.slot !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [199:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [23:0]  rsp_tdata;
   logic         csr_wr_en = 1'b0;
   logic [12:0]  csr_wr_data = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off = 1'b0;

   tag_scoreboard board = new();
   page_req_type  recent[$];

   always #10 clock = ~clock;

   hashed_page_tag_cache u_top (.*);

   // Result side: stall at random, check every accepted item.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_result(lookup_type'(rsp_tdata[19:0]));
         rsp_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send(page_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {7'd0, r.record, r.page, r.offset, r.file, r.present};
      do @(posedge clock); while (!req_tready);
      board.note_request(r);
      recent.push_back(r);
      if (recent.size() > 32) void'(recent.pop_front());
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      // invalid items never wait in the pipe long; allow a full lookup anyway
      repeat (80) @(posedge clock);
   endtask

   task automatic write_slots(logic [12:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.slot_count = value;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Mostly valid requests over a small page set so hits happen; the rest noise.
   function automatic page_req_type random_req();
      page_req_type r;
      int           pick;
      pick = $urandom_range(99);
      if (pick < 45 && recent.size() != 0) begin
         r = recent[$urandom_range(recent.size() - 1)];
         r.record = $urandom_range(REC_LIMIT - 1);
         r.present = 1'b1;
      end else begin
         r.kind    = $urandom_range(1);
         r.present = 1'b1;
         r.file    = pick < 75 ? 64'($urandom_range(7)) : rand64();
         r.offset  = pick < 75 ? 64'($urandom_range(15) * 4096) : rand64();
         r.page    = pick < 75 ? 32'($urandom_range(31)) : $urandom();
         r.record  = $urandom_range(REC_LIMIT - 1);
         if (pick >= 92) r.present = 1'b0;
         else if (pick >= 86) r.record = $urandom_range(1) ? $urandom() : REC_LIMIT;
      end
      return r;
   endfunction

   initial begin
      page_req_type r;
      logic [12:0]  settings[6] = '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd100, 13'd64};
      int           idle_send[4] = '{0, 47, 0, 25};
      int           idle_recv[4] = '{0, 0, 47, 25};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, both kinds, invalid cases, repeat for a hit.
      for (int i = 0; i < 12; i++) begin
         r.kind    = i[0];
         r.present = (i != 4);
         r.file    = i[1] ? '1 : '0;
         r.offset  = i[2] ? '1 : '0;
         r.page    = i[3] ? '1 : '0;
         r.record  = (i == 5) ? REC_LIMIT : (i == 6) ? '1 : (i == 7) ? REC_LIMIT - 1 : 0;
         send(r);
         if (i == 3) send(r);
      end
      drain();
      write_slots(13'd0);
      send(r);
      r.present = 1'b0;
      send(r);
      drain();

      // Random phases through every slot setting and idling mix.
      for (int p = 0; p < 6; p++) begin
         write_slots(settings[p]);
         send_idle_pct  = idle_send[p % 4];
         recv_stall_pct = idle_recv[p % 4];
         for (int n = 0; n < 220; n++) begin
            if (p == 2 && n == 50) fork
               begin
                  hold_off = 1'b1;
                  repeat (400) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
            send(random_req());
         end
         drain();
      end

      $display("Covered %0d lookups: %0d hits, %0d fills, six slot-count settings.",
               board.checked, board.hits, board.fills);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #60000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule

// ----- hashed_page_tag_cache.f -----
hdl/hptc_pkg.sv
hdl/hptc_ram.sv
hdl/hptc_datapath.sv
hdl/hptc_ctrl.sv
hdl/hashed_page_tag_cache.sv
dv/tb.sv
